>>> rtl/mmsvf_pkg.sv
// Shared types, constants and the control store of the multimode state variable filter.
package mmsvf_pkg;

	// Default widths of the fixed-point formats
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF   = 32;
	localparam int STATE_WIDTH_DEF  = 40;

	// Coefficients carry this many integer bits, the rest are fraction
	localparam int COEF_INT_BITS = 8;

	// Configuration register file
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WARP_COEF  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_NORM_COEF  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DAMP_COEF  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_HP    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_BP    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_LP    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_STATE = 3'd7;

	// Registers that come out of reset at 1.0 (input gain, norm, lowpass gain)
	localparam logic [NUM_REGS-1:0] REG_RESET_ONE = 8'b0100_0101;

	// Step counter
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = 5'd27;

	// Multiplier pass: each product is built from a low and a high half
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LO,
		MUL_HI
	} mul_op_t;

	// Multiplier signal operand
	typedef enum logic [2:0] {
		SIG_IN,
		SIG_S1,
		SIG_S2,
		SIG_T,
		SIG_HP,
		SIG_BP,
		SIG_LP
	} sig_sel_t;

	// Operation on the multiplier result
	typedef enum logic [3:0] {
		ALU_NONE,
		ALU_SAVE,
		ALU_T,
		ALU_HP,
		ALU_BP,
		ALU_S1,
		ALU_LP,
		ALU_S2,
		ALU_ACC0,
		ALU_ACC,
		ALU_OUT
	} alu_op_t;

	// Sequencing of the step counter
	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_LAST
	} seq_op_t;

	// One control word
	typedef struct packed {
		mul_op_t                mul;
		logic [REG_IDX_W-1:0]   coef_sel;
		sig_sel_t               sig;
		alu_op_t                alu;
		seq_op_t                seq;
	} ucode_t;

	// Control from the sequencer to the datapath
	typedef struct packed {
		logic   load;
		ucode_t uw;
	} dp_ctl_t;

	// Control into the multiplier
	typedef struct packed {
		logic issue;
		logic hi;
	} mul_ctl_t;

	function automatic ucode_t uw_make(input mul_op_t m, input logic [REG_IDX_W-1:0] c,
			input sig_sel_t s, input alu_op_t a, input seq_op_t q);
		ucode_t w;
		w.mul      = m;
		w.coef_sel = c;
		w.sig      = s;
		w.alu      = a;
		w.seq      = q;
		return w;
	endfunction

	// Microprogram; the ALU takes products from the multiplier result register.
	function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_NONE, SEQ_NEXT);
		unique case (step)
			5'd0:  w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_NONE, SEQ_WAIT_IN);
			// damping feedback on the old first state
			5'd1:  w = uw_make(MUL_LO, REG_DAMP_COEF, SIG_S1, ALU_NONE, SEQ_NEXT);
			5'd2:  w = uw_make(MUL_HI, REG_DAMP_COEF, SIG_S1, ALU_NONE, SEQ_NEXT);
			// input scaling
			5'd3:  w = uw_make(MUL_LO, REG_INPUT_GAIN, SIG_IN, ALU_NONE, SEQ_NEXT);
			5'd4:  w = uw_make(MUL_HI, REG_INPUT_GAIN, SIG_IN, ALU_NONE, SEQ_NEXT);
			// state tap on the old first state; keep damping term
			5'd5:  w = uw_make(MUL_LO, REG_GAIN_STATE, SIG_S1, ALU_SAVE, SEQ_NEXT);
			5'd6:  w = uw_make(MUL_HI, REG_GAIN_STATE, SIG_S1, ALU_NONE, SEQ_NEXT);
			5'd7:  w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_T, SEQ_NEXT);
			// highpass normalisation; start output sum with the state tap
			5'd8:  w = uw_make(MUL_LO, REG_NORM_COEF, SIG_T, ALU_NONE, SEQ_NEXT);
			5'd9:  w = uw_make(MUL_HI, REG_NORM_COEF, SIG_T, ALU_ACC0, SEQ_NEXT);
			5'd10, 5'd11, 5'd25, 5'd26:
				w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_NONE, SEQ_NEXT);
			5'd12: w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_HP, SEQ_NEXT);
			// first integrator and highpass output weight
			5'd13: w = uw_make(MUL_LO, REG_WARP_COEF, SIG_HP, ALU_NONE, SEQ_NEXT);
			5'd14: w = uw_make(MUL_HI, REG_WARP_COEF, SIG_HP, ALU_NONE, SEQ_NEXT);
			5'd15: w = uw_make(MUL_LO, REG_GAIN_HP, SIG_HP, ALU_NONE, SEQ_NEXT);
			5'd16: w = uw_make(MUL_HI, REG_GAIN_HP, SIG_HP, ALU_NONE, SEQ_NEXT);
			5'd17: w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_BP, SEQ_NEXT);
			// second integrator, first state update
			5'd18: w = uw_make(MUL_LO, REG_WARP_COEF, SIG_BP, ALU_S1, SEQ_NEXT);
			5'd19: w = uw_make(MUL_HI, REG_WARP_COEF, SIG_BP, ALU_ACC, SEQ_NEXT);
			5'd20: w = uw_make(MUL_LO, REG_GAIN_BP, SIG_BP, ALU_NONE, SEQ_NEXT);
			5'd21: w = uw_make(MUL_HI, REG_GAIN_BP, SIG_BP, ALU_NONE, SEQ_NEXT);
			5'd22: w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_LP, SEQ_NEXT);
			// lowpass output weight, second state update
			5'd23: w = uw_make(MUL_LO, REG_GAIN_LP, SIG_LP, ALU_S2, SEQ_NEXT);
			5'd24: w = uw_make(MUL_HI, REG_GAIN_LP, SIG_LP, ALU_ACC, SEQ_NEXT);
			5'd27: w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_OUT, SEQ_LAST);
			default: w = uw_make(MUL_NONE, REG_INPUT_GAIN, SIG_IN, ALU_NONE, SEQ_LAST);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/multimode_state_variable_filter.sv
// Top level of the multimode state variable filter: configuration registers and the two units.
//
//  channel  signals                                  width          direction
//  in       in_valid, in_ready, sample_in            SAMPLE_WIDTH   into block
//  out      out_valid, out_ready, sample_out         SAMPLE_WIDTH   out of block
//  cfg      cfg_valid, cfg_ready, cfg_index,         3 / COEF_WIDTH into block
//           cfg_data
//
// A sample is taken at the first microcode step and then runs through the remaining steps, whose
// order is set by the chain of dependent products through the single shared multiplier (each
// product built from a low and a high half, accumulated and then rounded).
// Reset clears both integrator states and loads the coefficient defaults; no clearing pass.
// A new input beat is taken only while the sequencer sits at its first step; the result waits
// in the output register, and the sequencer holds at its last step while that register is full and not taken.
// cfg_ready is always high; writes are meant to happen while the block is idle.
module multimode_state_variable_filter #(
	parameter int SAMPLE_WIDTH = mmsvf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = mmsvf_pkg::COEF_WIDTH_DEF,
	parameter int STATE_WIDTH  = mmsvf_pkg::STATE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mmsvf_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic signed [COEF_WIDTH-1:0]        cfg_data
);

	localparam logic [COEF_WIDTH-1:0] COEF_ONE = {{(mmsvf_pkg::COEF_INT_BITS-1){1'b0}}, 1'b1,
		{(COEF_WIDTH-mmsvf_pkg::COEF_INT_BITS){1'b0}}};

	logic signed [COEF_WIDTH-1:0] coef_q [mmsvf_pkg::NUM_REGS];
	logic signed [COEF_WIDTH-1:0] coef;
	mmsvf_pkg::dp_ctl_t           ctl;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mmsvf_pkg::NUM_REGS; i++)
				coef_q[i] <= mmsvf_pkg::REG_RESET_ONE[i] ? COEF_ONE : '0;
		end else if (cfg_valid) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// Coefficient for the current multiplier pass
	assign coef = coef_q[ctl.uw.coef_sel];

	mmsvf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	mmsvf_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH),
		.STATE_WIDTH  (STATE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.coef       (coef),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule

>>> rtl/mmsvf_mul.sv
// Coefficient multiplier in halves with round-half-away and state-width saturation.
module mmsvf_mul #(
	parameter int COEF_WIDTH  = mmsvf_pkg::COEF_WIDTH_DEF,
	parameter int STATE_WIDTH = mmsvf_pkg::STATE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmsvf_pkg::mul_ctl_t           ctl,
	input  logic signed [COEF_WIDTH-1:0]  coef,
	input  logic signed [STATE_WIDTH-1:0] sig,
	output logic signed [STATE_WIDTH-1:0] res
);

	localparam int FRAC = COEF_WIDTH - mmsvf_pkg::COEF_INT_BITS;
	localparam int LO_W = (STATE_WIDTH + 1) / 2;
	localparam int HI_W = STATE_WIDTH - LO_W;
	localparam int OPW  = LO_W + 1;
	localparam int PP_W = COEF_WIDTH + OPW;
	localparam int P_W  = COEF_WIDTH + STATE_WIDTH;
	localparam int QW   = P_W - FRAC;
	localparam logic [P_W-1:0] HALF = {{(P_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	logic signed [HI_W-1:0]        sig_hi;
	logic signed [OPW-1:0]         op;
	logic signed [PP_W-1:0]        coef_ext;
	logic signed [PP_W-1:0]        op_ext;
	logic signed [PP_W-1:0]        pp_d;
	logic signed [PP_W-1:0]        pp_s1;
	logic                          pp_v_s1;
	logic                          pp_hi_s1;
	logic signed [P_W-1:0]         pp_ext;
	logic signed [P_W-1:0]         acc_s2;
	logic [P_W-1:0]                rnd;
	logic signed [QW-1:0]          quo;
	logic                          ovf;
	logic signed [STATE_WIDTH-1:0] res_s3;

	// Half select: low half unsigned, high half signed
	assign sig_hi   = sig[STATE_WIDTH-1:LO_W];
	assign op       = ctl.hi ? OPW'(sig_hi) : {1'b0, sig[LO_W-1:0]};
	assign coef_ext = PP_W'(coef);
	assign op_ext   = PP_W'(op);
	assign pp_d     = coef_ext * op_ext;

	// Partial product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_v_s1  <= 1'b0;
			pp_hi_s1 <= 1'b0;
		end else begin
			pp_v_s1  <= ctl.issue;
			pp_hi_s1 <= ctl.hi;
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= pp_d;
	end

	// Accumulate: low half loads, high half adds shifted
	assign pp_ext = P_W'(pp_s1);

	always_ff @(posedge clk) begin
		if (pp_v_s1) begin
			if (pp_hi_s1)
				acc_s2 <= acc_s2 + (pp_ext <<< LO_W);
			else
				acc_s2 <= pp_ext;
		end
	end

	// Round to nearest, ties away from zero, then drop the fraction
	assign rnd = acc_s2 + HALF - {{(P_W-1){1'b0}}, acc_s2[P_W-1]};
	assign quo = rnd[P_W-1:FRAC];
	assign ovf = (quo[QW-1:STATE_WIDTH-1] != {(QW-STATE_WIDTH+1){quo[QW-1]}});

	always_ff @(posedge clk) begin
		if (ovf)
			res_s3 <= {quo[QW-1], {(STATE_WIDTH-1){~quo[QW-1]}}};
		else
			res_s3 <= quo[STATE_WIDTH-1:0];
	end

	assign res = res_s3;

endmodule

>>> rtl/mmsvf_seq.sv
// Microcode sequencer: step counter, control store and the channel handshakes.
module mmsvf_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mmsvf_pkg::dp_ctl_t  ctl
);

	logic [mmsvf_pkg::STEP_W-1:0] step_q;
	logic [mmsvf_pkg::STEP_W-1:0] step_d;
	logic                         out_valid_q;
	logic                         out_valid_d;
	logic                         stall;
	mmsvf_pkg::ucode_t            word;

	// Decode the current word and pick the next step
	always_comb begin
		word     = mmsvf_pkg::ucode(step_q);
		step_d   = step_q;
		stall    = 1'b0;
		in_ready = 1'b0;
		ctl.load = 1'b0;
		unique case (word.seq)
			mmsvf_pkg::SEQ_WAIT_IN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					step_d   = step_q + 1'b1;
				end else begin
					stall = 1'b1;
				end
			end
			mmsvf_pkg::SEQ_NEXT: begin
				step_d = step_q + 1'b1;
			end
			mmsvf_pkg::SEQ_LAST: begin
				// hold until the output register is free
				if (out_valid_q && !out_ready)
					stall = 1'b1;
				else
					step_d = '0;
			end
			default: begin
				step_d = '0;
			end
		endcase
		ctl.uw = word;
		if (stall) begin
			ctl.uw.mul = mmsvf_pkg::MUL_NONE;
			ctl.uw.alu = mmsvf_pkg::ALU_NONE;
		end
		out_valid_d = (out_valid_q && !out_ready) || (ctl.uw.alu == mmsvf_pkg::ALU_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (step_q == 5'd1))
		else $error("sequencer did not start after an input beat");
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(step_q) == mmsvf_pkg::LAST_STEP))
		else $error("result beat raised outside the last step");
	a_blocked_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == mmsvf_pkg::LAST_STEP && out_valid && !out_ready)
		|-> (ctl.uw.alu == mmsvf_pkg::ALU_NONE && ctl.uw.mul == mmsvf_pkg::MUL_NONE))
		else $error("datapath active while the output is blocked");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= mmsvf_pkg::LAST_STEP)
		else $error("step counter past the end of the program");
`endif

endmodule

>>> rtl/mmsvf_dp.sv
// Filter datapath: operand selection, shared multiplier, saturating adder and filter state.
module mmsvf_dp #(
	parameter int SAMPLE_WIDTH = mmsvf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = mmsvf_pkg::COEF_WIDTH_DEF,
	parameter int STATE_WIDTH  = mmsvf_pkg::STATE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mmsvf_pkg::dp_ctl_t             ctl,
	input  logic signed [COEF_WIDTH-1:0]   coef,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	localparam int AW = STATE_WIDTH + 2;

	logic signed [SAMPLE_WIDTH-1:0] in_q;
	logic signed [STATE_WIDTH-1:0]  s1_q;
	logic signed [STATE_WIDTH-1:0]  s2_q;
	logic signed [STATE_WIDTH-1:0]  t_q;
	logic signed [STATE_WIDTH-1:0]  hp_q;
	logic signed [STATE_WIDTH-1:0]  bp_q;
	logic signed [STATE_WIDTH-1:0]  lp_q;
	logic signed [STATE_WIDTH-1:0]  tmp_q;
	logic signed [AW-1:0]           yacc_q;
	logic signed [SAMPLE_WIDTH-1:0] out_q;
	logic signed [STATE_WIDTH-1:0]  sig;
	logic signed [STATE_WIDTH-1:0]  res;
	logic signed [AW-1:0]           res_ext;
	logic signed [AW-1:0]           opa;
	logic signed [AW-1:0]           opb;
	logic signed [AW-1:0]           opc;
	logic signed [AW-1:0]           sum;
	logic signed [STATE_WIDTH-1:0]  sum_sat;
	logic signed [AW-1:0]           yfin;
	mmsvf_pkg::mul_ctl_t            mul_ctl;

	function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [AW-1:0] v);
		logic ok;
		ok = (v[AW-1:STATE_WIDTH-1] == {(AW-STATE_WIDTH+1){v[AW-1]}});
		return ok ? v[STATE_WIDTH-1:0] : {v[AW-1], {(STATE_WIDTH-1){~v[AW-1]}}};
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [AW-1:0] v);
		logic ok;
		ok = (v[AW-1:SAMPLE_WIDTH-1] == {(AW-SAMPLE_WIDTH+1){v[AW-1]}});
		return ok ? v[SAMPLE_WIDTH-1:0] : {v[AW-1], {(SAMPLE_WIDTH-1){~v[AW-1]}}};
	endfunction

	// Multiplier signal operand
	always_comb begin
		case (ctl.uw.sig)
			mmsvf_pkg::SIG_IN: sig = STATE_WIDTH'(in_q);
			mmsvf_pkg::SIG_S1: sig = s1_q;
			mmsvf_pkg::SIG_S2: sig = s2_q;
			mmsvf_pkg::SIG_T:  sig = t_q;
			mmsvf_pkg::SIG_HP: sig = hp_q;
			mmsvf_pkg::SIG_BP: sig = bp_q;
			mmsvf_pkg::SIG_LP: sig = lp_q;
			default:           sig = '0;
		endcase
	end

	assign mul_ctl.issue = (ctl.uw.mul != mmsvf_pkg::MUL_NONE);
	assign mul_ctl.hi    = (ctl.uw.mul == mmsvf_pkg::MUL_HI);

	mmsvf_mul #(
		.COEF_WIDTH  (COEF_WIDTH),
		.STATE_WIDTH (STATE_WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.coef   (coef),
		.sig    (sig),
		.res    (res)
	);

	// Shared three-input adder; highpass input takes two negated terms
	assign res_ext = AW'(res);

	always_comb begin
		opa = '0;
		opb = '0;
		opc = '0;
		case (ctl.uw.alu)
			mmsvf_pkg::ALU_T: begin
				opa = res_ext;
				opb = -AW'(tmp_q);
				opc = -AW'(s2_q);
			end
			mmsvf_pkg::ALU_BP: begin
				opa = res_ext;
				opb = AW'(s1_q);
			end
			mmsvf_pkg::ALU_S1: begin
				opa = AW'(tmp_q);
				opb = AW'(bp_q);
			end
			mmsvf_pkg::ALU_LP: begin
				opa = res_ext;
				opb = AW'(s2_q);
			end
			mmsvf_pkg::ALU_S2: begin
				opa = AW'(tmp_q);
				opb = AW'(lp_q);
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	assign sum     = opa + opb + opc;
	assign sum_sat = sat_state(sum);
	assign yfin    = yacc_q + res_ext;

	// Integrator states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			if (ctl.uw.alu == mmsvf_pkg::ALU_S1)
				s1_q <= sum_sat;
			if (ctl.uw.alu == mmsvf_pkg::ALU_S2)
				s2_q <= sum_sat;
		end
	end

	// Working registers and output accumulation
	always_ff @(posedge clk) begin
		if (ctl.load)
			in_q <= sample_in;
		case (ctl.uw.alu)
			mmsvf_pkg::ALU_SAVE: tmp_q <= res;
			mmsvf_pkg::ALU_T:    t_q   <= sum_sat;
			mmsvf_pkg::ALU_HP:   hp_q  <= res;
			mmsvf_pkg::ALU_BP: begin
				tmp_q <= res;
				bp_q  <= sum_sat;
			end
			mmsvf_pkg::ALU_LP: begin
				tmp_q <= res;
				lp_q  <= sum_sat;
			end
			mmsvf_pkg::ALU_ACC0: yacc_q <= res_ext;
			mmsvf_pkg::ALU_ACC:  yacc_q <= yfin;
			mmsvf_pkg::ALU_OUT:  out_q  <= sat_out(yfin);
			default: begin
			end
		endcase
	end

	assign sample_out = out_q;

endmodule

>>> tb/tb_multimode_state_variable_filter.sv
// Self-checking testbench for the multimode state variable filter, with its scoreboard.
module tb_multimode_state_variable_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import mmsvf_pkg::*;

	localparam int SW   = SAMPLE_WIDTH_DEF;
	localparam int CW   = COEF_WIDTH_DEF;
	localparam int STW  = STATE_WIDTH_DEF;
	localparam int FRAC = CW - COEF_INT_BITS;

	// Cycles let pass before a register write once the last result is out
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 120;

	typedef logic signed [SW-1:0] sample_t;
	typedef logic signed [CW-1:0] coef_t;

	localparam sample_t SMP_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam sample_t SMP_MIN  = {1'b1, {(SW-1){1'b0}}};
	localparam coef_t   COEF_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coef_t   COEF_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam coef_t   COEF_ONE = coef_t'(1) <<< FRAC;

	typedef enum int {
		CFG_TUNED,
		CFG_RANDOM,
		CFG_ALL_MAX,
		CFG_ALL_MIN,
		CFG_MIXED
	} cfg_kind_e;

	// Bit-true filter predictor and queue of expected output beats
	class svf_scoreboard;
		longint  coef [NUM_REGS];
		longint  integ1;
		longint  integ2;
		sample_t expected_out_q [$];
		int      errors;

		function new();
			for (int i = 0; i < NUM_REGS; i++)
				coef[i] = 0;
			coef[REG_INPUT_GAIN] = longint'(1) <<< FRAC;
			coef[REG_NORM_COEF]  = longint'(1) <<< FRAC;
			coef[REG_GAIN_LP]    = longint'(1) <<< FRAC;
			integ1 = 0;
			integ2 = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, coef_t d);
			coef[idx] = longint'(d);
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		// Coefficient times signal: round half away from zero, drop the fraction, saturate
		function longint qmul(longint c, longint s);
			bit         neg;
			bit [127:0] ma;
			bit [127:0] mb;
			bit [127:0] prod;
			bit [127:0] lim;
			neg  = (c < 0) != (s < 0);
			ma   = (c < 0) ? 128'(-c) : 128'(c);
			mb   = (s < 0) ? 128'(-s) : 128'(s);
			prod = ((ma * mb) + (128'd1 << (FRAC - 1))) >> FRAC;
			lim  = 128'd1 << (STW - 1);
			if (neg) begin
				if (prod > lim)
					prod = lim;
				return -longint'(prod[63:0]);
			end
			if (prod > lim - 1)
				prod = lim - 1;
			return longint'(prod[63:0]);
		endfunction

		// One sample through the filter; updates both integrators
		function void note_input(sample_t smp);
			longint s1, s2, x, t, hp, ah, bp, ab, lp, y;
			s1 = integ1;
			s2 = integ2;
			x  = qmul(coef[REG_INPUT_GAIN], longint'(smp));
			t  = clamp(x - qmul(coef[REG_DAMP_COEF], s1) - s2, STW);
			hp = qmul(coef[REG_NORM_COEF], t);
			ah = qmul(coef[REG_WARP_COEF], hp);
			bp = clamp(ah + s1, STW);
			ab = qmul(coef[REG_WARP_COEF], bp);
			lp = clamp(ab + s2, STW);
			integ1 = clamp(ah + bp, STW);
			integ2 = clamp(ab + lp, STW);
			y = qmul(coef[REG_GAIN_HP], hp) + qmul(coef[REG_GAIN_BP], bp)
				+ qmul(coef[REG_GAIN_LP], lp) + qmul(coef[REG_GAIN_STATE], s1);
			expected_out_q.push_back(sample_t'(clamp(y, SW)));
		endfunction

		function void check_output(sample_t got);
			sample_t exp_val;
			if (expected_out_q.size() == 0) begin
				$error("sample_out: beat with nothing expected, actual %0d", got);
				errors++;
				return;
			end
			exp_val = expected_out_q.pop_front();
			if (got !== exp_val) begin
				$error("sample_out: expected %0d, actual %0d", exp_val, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_out_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              sample_in;
	logic                 out_valid;
	logic                 out_ready;
	sample_t              sample_out;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	coef_t                cfg_data;

	svf_scoreboard sb = new();
	coef_t         cfg_set [NUM_REGS];
	bit            in_gap_en;
	bit            out_stall_en;
	sample_t       last_smp;

	multimode_state_variable_filter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic real frac();
		return $urandom_range(0, 10000) / 10000.0;
	endfunction

	function automatic coef_t to_q(real v);
		return coef_t'($rtoi(v * 16777216.0));
	endfunction

	// Random sample: extremes, small values, held values and full-range noise
	function automatic sample_t rand_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: last_smp = SMP_MAX;
			1: last_smp = SMP_MIN;
			2: last_smp = sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
			3: last_smp = last_smp;
			default: last_smp = sample_t'($urandom);
		endcase
		return last_smp;
	endfunction

	// Fill the coefficient set for one phase
	function automatic void make_config(cfg_kind_e kind);
		real a;
		real r;
		real rho;
		case (kind)
			CFG_TUNED: begin
				a   = 0.002 + 1.6 * frac();
				r   = 0.05 + 2.0 * frac();
				rho = 2.0 * r + a;
				cfg_set[REG_INPUT_GAIN] = to_q(0.25 + 1.75 * frac());
				cfg_set[REG_WARP_COEF]  = to_q(a);
				cfg_set[REG_NORM_COEF]  = to_q(1.0 / (1.0 + a * rho));
				cfg_set[REG_DAMP_COEF]  = to_q(rho);
				cfg_set[REG_GAIN_HP]    = to_q(4.0 * frac() - 2.0);
				cfg_set[REG_GAIN_BP]    = to_q(4.0 * frac() - 2.0);
				cfg_set[REG_GAIN_LP]    = to_q(4.0 * frac() - 2.0);
				cfg_set[REG_GAIN_STATE] = (frac() < 0.5) ? '0 : to_q(2.0 * frac() - 1.0);
			end
			CFG_RANDOM: begin
				for (int i = 0; i < NUM_REGS; i++)
					cfg_set[i] = coef_t'($urandom);
			end
			CFG_ALL_MAX: begin
				for (int i = 0; i < NUM_REGS; i++)
					cfg_set[i] = COEF_MAX;
			end
			CFG_ALL_MIN: begin
				for (int i = 0; i < NUM_REGS; i++)
					cfg_set[i] = COEF_MIN;
			end
			default: begin
				for (int i = 0; i < NUM_REGS; i++) begin
					case ($urandom_range(0, 5))
						0: cfg_set[i] = '0;
						1: cfg_set[i] = COEF_MAX;
						2: cfg_set[i] = COEF_MIN;
						3: cfg_set[i] = COEF_ONE;
						4: cfg_set[i] = -COEF_ONE;
						default: cfg_set[i] = coef_t'($urandom);
					endcase
				end
			end
		endcase
	endfunction

	// One register write beat
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, coef_t d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_config();
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(REG_IDX_W'(i), cfg_set[i]);
	endtask

	// Hold off until every expected beat has come back
	task automatic wait_drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Drain, let the sequencer settle, then load a new set
	task automatic reconfigure();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_config();
	endtask

	// Present one sample beat, then, if gap is nonzero, drop in_valid for the gap given
	task automatic send_sample(sample_t v, int gap);
		@(negedge clk);
		in_valid  <= 1'b1;
		sample_in <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_input(v);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic int next_gap();
		return in_gap_en ? pick_gap() : 0;
	endfunction

	// Receiver back-pressure
	initial begin
		int g;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_stall_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				g = pick_gap() + 1;
				repeat (g) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Output beat check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_output(sample_out);
	end

	// Stimulus
	initial begin
		sample_t dir_tuned [9];
		int      n;
		int      drain_at;
		int      g;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_gap_en    = 1'b1;
		out_stall_en = 1'b1;
		last_smp     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Coefficients as they come out of reset
		send_sample(SMP_MAX, next_gap());
		send_sample(SMP_MIN, next_gap());
		send_sample(sample_t'(1), 1);

		// Moderate filter, hp + bp + lp + state tap, driven with extremes, then 0, -1 and 1
		cfg_set[REG_INPUT_GAIN] = COEF_ONE;
		cfg_set[REG_WARP_COEF]  = to_q(0.25);
		cfg_set[REG_NORM_COEF]  = to_q(1.0 / 1.3125);
		cfg_set[REG_DAMP_COEF]  = to_q(1.25);
		cfg_set[REG_GAIN_HP]    = COEF_ONE;
		cfg_set[REG_GAIN_BP]    = -COEF_ONE;
		cfg_set[REG_GAIN_LP]    = to_q(0.5);
		cfg_set[REG_GAIN_STATE] = to_q(0.25);
		reconfigure();
		dir_tuned = '{SMP_MAX, SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN, SMP_MIN,
			sample_t'(0), sample_t'(-1), sample_t'(1)};
		foreach (dir_tuned[i])
			send_sample(dir_tuned[i], (i == 8) ? 1 : next_gap());

		// Largest positive coefficients: saturation everywhere
		make_config(CFG_ALL_MAX);
		reconfigure();
		send_sample(SMP_MAX, next_gap());
		send_sample(SMP_MIN, next_gap());
		send_sample(SMP_MAX, next_gap());
		send_sample(sample_t'(0), 1);

		// Most negative coefficients
		make_config(CFG_ALL_MIN);
		reconfigure();
		send_sample(SMP_MAX, next_gap());
		send_sample(SMP_MIN, next_gap());
		send_sample(sample_t'(-1), next_gap());
		send_sample(sample_t'(1), 1);

		// All coefficients zero
		for (int i = 0; i < NUM_REGS; i++)
			cfg_set[i] = '0;
		reconfigure();
		send_sample(sample_t'(1), next_gap());
		send_sample(SMP_MIN, 1);

		// Random phases, one coefficient set each
		for (int p = 0; p < PHASES; p++) begin
			in_gap_en    = (p == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);
			out_stall_en = (p == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);
			make_config(cfg_kind_e'(p % 5));
			reconfigure();
			n        = PHASE_ITEMS;
			drain_at = $urandom_range(10, n - 10);
			for (int i = 0; i < n; i++) begin
				if (i == drain_at)
					wait_drain();
				g = next_gap();
				if (i == n - 1 || i + 1 == drain_at)
					g = g + 1;
				send_sample(rand_sample(), g);
			end
		end

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
rtl/mmsvf_pkg.sv
rtl/mmsvf_mul.sv
rtl/mmsvf_seq.sv
rtl/mmsvf_dp.sv
rtl/multimode_state_variable_filter.sv
tb/tb_multimode_state_variable_filter.sv
